### rtl/sos_pkg.sv
package sos_pkg;

  // Series length limit and derived counter width
  localparam int unsigned MAX_POINTS = 65536;
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);

  // Q16.16 one
  localparam logic signed [63:0] ONE_Q16 = 64'sd65536;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd1;

  // Divider step counter
  localparam int unsigned DIV_STEP_W = 7;
  localparam logic [DIV_STEP_W-1:0] DIV_STEPS_FULL = 7'd64;
  localparam logic [DIV_STEP_W-1:0] DIV_STEPS_Q16  = 7'd48;

  typedef struct packed {
    logic signed [31:0] sample_a;
    logic signed [31:0] sample_b;
    logic               last_pair;
  } in_t;

  typedef struct packed {
    logic signed [31:0] score;
    logic [16:0]        empty_points;
    logic               invalid;
  } out_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PAIR,
    OP_SQ,
    OP_SQADD,
    OP_DIVT,
    OP_TERM,
    OP_DIVF,
    OP_SCORE_OV,
    OP_SQRT,
    OP_DIVR,
    OP_SCORE_DEV,
    OP_SCORE_ZERO,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic take;
    logic skip;
    logic near;
    logic last;
    logic cnt_zero;
    logic pk_zero;
    logic div_done;
    logic sqrt_done;
  } status_t;

endpackage

### rtl/sos_div.sv
module sos_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [32:0] divisor_i,
  input  logic [sos_pkg::DIV_STEP_W-1:0] steps_i,
  output logic        done_o,
  output logic [63:0] quot_o
);
  import sos_pkg::*;

  logic [63:0]           quot_q, quot_d;
  logic [32:0]           rem_q, rem_d;
  logic [32:0]           dsr_q, dsr_d;
  logic [DIV_STEP_W-1:0] cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [33:0]           trial;

  // One restoring step per cycle; dividend is left aligned by the caller
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[63]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = steps_i;
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d  = 33'(trial - {1'b0, dsr_q});
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = trial[32:0];
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == DIV_STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

### rtl/sos_sqrt.sv
module sos_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  import sos_pkg::*;

  logic [63:0] x_q, x_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [35:0] t;
  logic [35:0] trial;

  // Two radicand bits per cycle, one root bit out
  always_comb begin
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    t      = {rem_q, x_q[63:62]};
    trial  = {2'b00, root_q, 2'b01};
    if (start_i) begin
      x_d    = x_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      x_d = {x_q[61:0], 2'b00};
      if (t >= trial) begin
        rem_d  = 34'(t - trial);
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = t[33:0];
        root_d = {root_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

### rtl/sos_datapath.sv
module sos_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sos_pkg::cmd_t     cmd_i,
  output sos_pkg::status_t  status_o,
  input  sos_pkg::in_t      in_data_i,
  input  logic              mode_i,
  input  logic [15:0]       thr_i,
  output sos_pkg::out_t     out_data_o
);
  import sos_pkg::*;

  function automatic logic [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sd2147483647)       return 32'h7FFF_FFFF;
    else if (v < -65'sd2147483648) return 32'h8000_0000;
    else                           return v[31:0];
  endfunction

  logic signed [31:0] a_q, b_q, peak_q, peak_d;
  logic               last_q;
  logic [63:0]        sum_q, sum_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d, tot_q, tot_d;
  logic [31:0]        dmag_q;
  logic signed [32:0] den_q;
  logic [63:0]        sq_q;
  logic [31:0]        score_q, score_d;
  logic               inv_q, inv_d;
  out_t               out_q;

  logic signed [32:0] a33, b33, diff, den, thr33;
  logic [32:0]        abs_a, abs_b, abs_d, abs_den;
  logic signed [31:0] hi;
  logic [31:0]        pk;
  logic               skip, near, take;

  logic               div_start, div_done, sqrt_done;
  logic [63:0]        div_dvd, div_quot;
  logic [32:0]        div_dsr;
  logic [DIV_STEP_W-1:0] div_steps;
  logic [31:0]        root;

  logic signed [63:0] tq, term;
  logic signed [64:0] acc65, val65;
  logic [64:0]        uacc65;
  logic [63:0]        sum_mag;
  logic [31:0]        e32;

  // Pair classification from the latched samples
  always_comb begin
    a33     = 33'(a_q);
    b33     = 33'(b_q);
    thr33   = $signed({17'b0, thr_i});
    diff    = a33 - b33;
    den     = a33 + b33;
    abs_a   = a33[32] ? 33'(-a33) : 33'(a33);
    abs_b   = b33[32] ? 33'(-b33) : 33'(b33);
    abs_d   = diff[32] ? 33'(-diff) : 33'(diff);
    abs_den = den[32] ? 33'(-den) : 33'(den);
    hi      = (a_q > b_q) ? a_q : b_q;
    skip    = ($signed(abs_a) < thr33) && ($signed(abs_b) < thr33);
    // magnitude of the sum may reach 2^32, so compare unsigned
    near    = (den == '0) || (abs_den < {17'b0, thr_i});
    take    = 32'(tot_q) < 32'(MAX_POINTS);
    pk      = peak_q[31] ? 32'(-peak_q) : 32'(peak_q);
    sum_mag = sum_q[63] ? 64'(-sum_q) : sum_q;
  end

  // Divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = '0;
    div_steps = DIV_STEPS_FULL;
    unique case (cmd_i.op)
      OP_DIVT: begin
        div_start = 1'b1;
        div_dvd   = {dmag_q, 32'b0};
        div_dsr   = 33'($unsigned(den_q[32] ? -den_q : den_q));
        div_steps = DIV_STEPS_Q16;
      end
      OP_DIVF: begin
        div_start = 1'b1;
        div_dvd   = mode_i ? sum_q : sum_mag;
        div_dsr   = 33'(cnt_q);
      end
      OP_DIVR: begin
        div_start = 1'b1;
        div_dvd   = {root, 32'b0};
        div_dsr   = {1'b0, pk};
        div_steps = DIV_STEPS_Q16;
      end
      default: ;
    endcase
  end

  sos_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dsr),
    .steps_i   (div_steps),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  sos_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.op == OP_SQRT),
    .x_i    (div_quot),
    .done_o (sqrt_done),
    .root_o (root)
  );

  // Series state and score updates
  always_comb begin
    peak_d  = peak_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    tot_d   = tot_q;
    score_d = score_q;
    inv_d   = inv_q;
    tq      = den_q[32] ? -$signed({16'b0, div_quot[47:0]})
                        : $signed({16'b0, div_quot[47:0]});
    term    = ONE_Q16 - tq;
    acc65   = 65'(signed'(sum_q)) + 65'(term);
    uacc65  = {1'b0, sum_q} + {1'b0, sq_q};
    val65   = '0;
    e32     = 32'(tot_q - cnt_q);
    unique case (cmd_i.op)
      OP_PAIR: begin
        if (take) begin
          if (tot_q == '0 || hi > peak_q) peak_d = hi;
          tot_d = tot_q + 1'b1;
          if (mode_i || !skip) cnt_d = cnt_q + 1'b1;
        end
      end
      OP_SQADD: begin
        sum_d = uacc65[64] ? '1 : uacc65[63:0];
      end
      OP_TERM: begin
        if (acc65[64] != acc65[63])
          sum_d = acc65[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        else
          sum_d = acc65[63:0];
      end
      OP_SCORE_OV: begin
        val65   = sum_q[63] ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
        score_d = sat32(val65);
        inv_d   = 1'b0;
      end
      OP_SCORE_DEV: begin
        val65   = 65'(ONE_Q16) - $signed({1'b0, div_quot});
        score_d = sat32(val65);
        inv_d   = 1'b0;
      end
      OP_SCORE_ZERO: begin
        score_d = '0;
        inv_d   = mode_i;
      end
      OP_OUT: begin
        peak_d = '0;
        sum_d  = '0;
        cnt_d  = '0;
        tot_d  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
      sum_q  <= '0;
      cnt_q  <= '0;
      tot_q  <= '0;
    end else begin
      peak_q <= peak_d;
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
      tot_q  <= tot_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    inv_q   <= inv_d;
    if (cmd_i.op == OP_LOAD) begin
      a_q    <= in_data_i.sample_a;
      b_q    <= in_data_i.sample_b;
      last_q <= in_data_i.last_pair;
    end
    if (cmd_i.op == OP_PAIR) begin
      dmag_q <= abs_d[31:0];
      den_q  <= den;
    end
    if (cmd_i.op == OP_SQ) sq_q <= dmag_q * dmag_q;
    if (cmd_i.op == OP_OUT) begin
      out_q.score        <= score_q;
      out_q.invalid      <= inv_q;
      out_q.empty_points <= mode_i ? 17'd0
                          : (e32 > 32'h1FFFF) ? 17'h1FFFF : e32[16:0];
    end
  end

  assign out_data_o         = out_q;
  assign status_o.mode      = mode_i;
  assign status_o.take      = take;
  assign status_o.skip      = skip;
  assign status_o.near      = near;
  assign status_o.last      = last_q;
  assign status_o.cnt_zero  = (cnt_q == '0);
  assign status_o.pk_zero   = (pk == '0);
  assign status_o.div_done  = div_done;
  assign status_o.sqrt_done = sqrt_done;
endmodule

### rtl/sos_ctrl.sv
module sos_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sos_pkg::status_t status_i,
  output sos_pkg::cmd_t    cmd_o,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i
);
  import sos_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PAIR  = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_SQADD = 4'd3;
  localparam logic [3:0] S_TSTRT = 4'd4;
  localparam logic [3:0] S_DIVT  = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_DIVF  = 4'd8;
  localparam logic [3:0] S_SQRT  = 4'd9;
  localparam logic [3:0] S_DIVR  = 4'd10;
  localparam logic [3:0] S_RES   = 4'd11;

  logic [3:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    ovalid_d   = ovalid_q && !out_ready_i;
    cmd_o.op   = OP_NONE;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_PAIR;
        end
      end
      S_PAIR: begin
        cmd_o.op = OP_PAIR;
        priority if (!status_i.take)                   state_d = S_CHK;
        else if (status_i.mode)                        state_d = S_SQ;
        else if (status_i.skip || status_i.near)       state_d = S_CHK;
        else                                           state_d = S_TSTRT;
      end
      S_SQ: begin
        cmd_o.op = OP_SQ;
        state_d  = S_SQADD;
      end
      S_SQADD: begin
        cmd_o.op = OP_SQADD;
        state_d  = S_CHK;
      end
      S_TSTRT: begin
        cmd_o.op = OP_DIVT;
        state_d  = S_DIVT;
      end
      S_DIVT: begin
        if (status_i.div_done) begin
          cmd_o.op = OP_TERM;
          state_d  = S_CHK;
        end
      end
      S_CHK: begin
        state_d = status_i.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (status_i.cnt_zero || (status_i.mode && status_i.pk_zero)) begin
          cmd_o.op = OP_SCORE_ZERO;
          state_d  = S_RES;
        end else begin
          cmd_o.op = OP_DIVF;
          state_d  = S_DIVF;
        end
      end
      S_DIVF: begin
        if (status_i.div_done) begin
          cmd_o.op = status_i.mode ? OP_SQRT : OP_SCORE_OV;
          state_d  = status_i.mode ? S_SQRT : S_RES;
        end
      end
      S_SQRT: begin
        if (status_i.sqrt_done) begin
          cmd_o.op = OP_DIVR;
          state_d  = S_DIVR;
        end
      end
      S_DIVR: begin
        if (status_i.div_done) begin
          cmd_o.op = OP_SCORE_DEV;
          state_d  = S_RES;
        end
      end
      S_RES: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.op = OP_OUT;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;
endmodule

### rtl/series_overlap_score_top.sv
// Scores the similarity of two series of signed Q16.16 sample pairs, one
// request per pair, one result on the pair flagged last_pair. A pair whose
// overlap term needs it uses the 48-step radix-2 divider; the last pair
// adds a 64-step mean division in overlap mode, and in deviation mode that
// division, a 32-step square root and a 48-step normalising division, unless
// the score is forced to zero; it may then wait for the output register.
// The one shared divider serves all of these divisions. A new request is
// taken while a result waits in the output register. The user must write
// score_mode and near_zero_threshold through the configuration port at
// indexes 0 and 1 only while idle; the block itself does not enforce it.
module series_overlap_score_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  sos_pkg::in_t                        in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output sos_pkg::out_t                       out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sos_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sos_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import sos_pkg::*;

  logic        mode_q;
  logic [15:0] thr_q;
  cmd_t        cmd;
  status_t     status;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      thr_q  <= 16'd1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_SCORE_MODE) mode_q <= cfg_data_i[0];
      if (cfg_index_i == REG_THRESHOLD)  thr_q  <= cfg_data_i[15:0];
    end
  end

  assign cfg_ready_o = 1'b1;

  sos_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i)
  );

  sos_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .in_data_i (in_data_i),
    .mode_i    (mode_q),
    .thr_i     (thr_q),
    .out_data_o(out_data_o)
  );
endmodule
